>>> hdl/mdh_forward_kinematics_chain_macros.svh
// Assertion macros for the forward kinematics chain.
`ifndef MDH_FORWARD_KINEMATICS_CHAIN_MACROS_SVH
`define MDH_FORWARD_KINEMATICS_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
`define MDHFK_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define MDHFK_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define MDHFK_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define MDHFK_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

>>> hdl/mdhfk_pkg.sv
// Shared constants, types and CORDIC angle table for the kinematics chain.
package mdhfk_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int ROT_W        = 18;
    localparam int POS_W        = 19;
    localparam int LEN_W        = 17;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;

    localparam logic signed [ROT_W-1:0] ONE = ROT_W'(64'sd1 <<< FRAC_BITS);

    // sine / cosine handed from the CORDIC unit to the sequencer
    typedef struct packed {
        logic                    done;
        logic signed [ROT_W-1:0] cos_val;
        logic signed [ROT_W-1:0] sin_val;
    } sincos_t;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [29:0] atan_step(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000028;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000002;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/mdhfk_cordic.sv
// Iterative CORDIC unit: one micro-rotation per cycle, gives sine and cosine.
module mdhfk_cordic (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [mdhfk_pkg::ANGLE_BITS-1:0]       angle,
    output mdhfk_pkg::sincos_t                     result
);

    localparam int W    = mdhfk_pkg::CORDIC_W;
    localparam int RSH  = 30 - mdhfk_pkg::FRAC_BITS;
    localparam logic signed [W-1:0] KINV  = W'(652032874);
    localparam logic signed [W-1:0] HALF  = W'(64'sd1 <<< (RSH - 1));
    localparam logic signed [W-1:0] ONE_C = W'(64'sd1 <<< mdhfk_pkg::FRAC_BITS);

    logic                busy_reg;
    logic                fin_reg;
    logic                flip_reg;
    logic [4:0]          step_reg;
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    mdhfk_pkg::sincos_t  result_reg;

    logic [31:0]         z32, zf;
    logic                flip;
    logic signed [W-1:0] dx, dy, at, xr, yr, xn, yn;

    // quadrant fold of the starting angle
    always_comb begin
        z32  = {angle, {(32 - mdhfk_pkg::ANGLE_BITS){1'b0}}};
        flip = 1'(((z32 + 32'h4000_0000) >> 31));
        zf   = flip ? z32 + 32'h8000_0000 : z32;
    end

    // shared shift / add step and final rounding
    always_comb begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = signed'(W'(mdhfk_pkg::atan_step(step_reg)));
        xr = (x_reg + HALF) >>> RSH;
        yr = (y_reg + HALF) >>> RSH;
        xn = flip_reg ? -xr : xr;
        yn = flip_reg ? -yr : yr;
    end

    function automatic logic signed [mdhfk_pkg::ROT_W-1:0] sat_one(
        input logic signed [W-1:0] v);
        logic signed [W-1:0] c;
        c = (v > ONE_C) ? ONE_C : ((v < -ONE_C) ? -ONE_C : v);
        return c[mdhfk_pkg::ROT_W-1:0];
    endfunction

    // sequencer for the micro-rotations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            fin_reg         <= 1'b0;
            result_reg.done <= 1'b0;
        end else begin
            result_reg.done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                step_reg <= '0;
                flip_reg <= flip;
                x_reg    <= KINV;
                y_reg    <= '0;
                z_reg    <= W'(signed'(zf));
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                if (step_reg == 5'(mdhfk_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end else begin
                    step_reg <= step_reg + 5'd1;
                end
            end else if (fin_reg) begin
                fin_reg            <= 1'b0;
                result_reg.done    <= 1'b1;
                result_reg.cos_val <= sat_one(xn);
                result_reg.sin_val <= sat_one(yn);
            end
        end
    end

    assign result = result_reg;

endmodule

>>> hdl/mdh_forward_kinematics_chain.sv
// Top level: modified DH forward kinematics over a six-joint chain.
//
// Input channel (s_*): one request carries a joint number and a binary angle.
// Joint 0 restarts the chain from the identity frame; every other joint
// multiplies its link transform onto the accumulated frame. Joint numbers 6
// and 7 are accepted and dropped with no result.
// Output channel (m_*): three results per request, rows x, y, z of the new
// cumulative frame, m_last high on row 2.
// Configuration channel (cfg_*): ready only while the block is idle; writes
// link lengths. Indexes above 4 are ignored.
// Timing: one request at a time. Sine and cosine come from the CORDIC unit
// after the request is accepted (start, load, 30 micro-rotations, rounding,
// handover); then each row takes 12 products on the single shared
// multiplier, each a multiply state and an accumulate state, and the row is
// then presented in the output state. The next request is accepted only after
// the last row of the previous one is taken, so an output stall delays it.
// A stall on m_ready holds the current row and pauses the sequencer.
// Reset (aresetn, synchronous) restores the identity frame, zero offset
// and the default link lengths.
`include "mdh_forward_kinematics_chain_macros.svh"

module mdh_forward_kinematics_chain (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [2:0]                               s_joint,
    input  logic [15:0]                              s_angle,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [2:0]                               m_frame,
    output logic [1:0]                               m_row,
    output logic signed [mdhfk_pkg::ROT_W-1:0]       m_rot_x,
    output logic signed [mdhfk_pkg::ROT_W-1:0]       m_rot_y,
    output logic signed [mdhfk_pkg::ROT_W-1:0]       m_rot_z,
    output logic signed [mdhfk_pkg::POS_W-1:0]       m_offset,
    output logic                                     m_last,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [2:0]                               cfg_index,
    input  logic [mdhfk_pkg::LEN_W-1:0]              cfg_data
);

    localparam int RW  = mdhfk_pkg::ROT_W;
    localparam int PW  = mdhfk_pkg::POS_W;
    localparam int LW  = mdhfk_pkg::LEN_W;
    localparam int BW  = 19;
    localparam int MW  = RW + BW;
    localparam int SW  = MW + 3;
    localparam logic signed [SW-1:0] HALF    = SW'(64'sd1 <<< (mdhfk_pkg::FRAC_BITS - 1));
    localparam logic signed [SW-1:0] ONE_S   = SW'(64'sd1 <<< mdhfk_pkg::FRAC_BITS);
    localparam logic signed [SW-1:0] POS_MAX = SW'(262143);
    localparam logic signed [SW-1:0] POS_MIN = -SW'(262144);

    typedef enum logic [2:0] {
        CFG_BASE_HEIGHT      = 3'd0,
        CFG_SHOULDER_OFFSET  = 3'd1,
        CFG_UPPER_ARM_LENGTH = 3'd2,
        CFG_FOREARM_LENGTH   = 3'd3,
        CFG_FLANGE_LENGTH    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SINCOS, ST_MUL, ST_ACC, ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [LW-1:0]          base_height_reg, shoulder_offset_reg, upper_arm_length_reg;
    logic [LW-1:0]          forearm_length_reg, flange_length_reg;
    logic signed [RW-1:0]   rot_reg [3][3];
    logic signed [PW-1:0]   pos_reg [3];
    logic signed [RW-1:0]   nrot_reg [3];
    logic [2:0]             joint_reg;
    logic [15:0]            angle_reg;
    logic signed [RW-1:0]   ct_reg, st_reg;
    logic [1:0]             row_reg, term_reg, k_reg;
    logic signed [MW-1:0]   prod_reg;
    logic signed [SW-1:0]   sum_reg;
    logic                   cordic_start_reg;
    logic [2:0]             frame_reg;
    logic [1:0]             orow_reg;
    logic signed [RW-1:0]   orx_reg, ory_reg, orz_reg;
    logic signed [PW-1:0]   ooff_reg;
    logic                   olast_reg;

    mdhfk_pkg::sincos_t     sc;

    logic                   ca_one, sa_pos, sa_neg;
    logic [LW-1:0]          len_a, len_d;
    logic signed [RW-1:0]   a_op;
    logic signed [BW-1:0]   b_op, ct_b, st_b, one_b, a_b, d_b;
    logic signed [SW-1:0]   sum_n, rnd, rot_c, pos_s, pos_c;
    logic                   s_fire, m_fire;

    mdhfk_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start_reg),
        .angle   (angle_reg[mdhfk_pkg::ANGLE_BITS-1:0]),
        .result  (sc)
    );

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // twist and link length selection for the current joint
    always_comb begin
        ca_one = (joint_reg == 3'd0) || (joint_reg == 3'd2);
        sa_neg = (joint_reg == 3'd4);
        sa_pos = !ca_one && !sa_neg;
        len_a  = '0;
        len_d  = '0;
        case (joint_reg)
            3'd0:    len_d = base_height_reg;
            3'd1:    len_a = shoulder_offset_reg;
            3'd2:    len_a = upper_arm_length_reg;
            3'd3:    len_d = forearm_length_reg;
            3'd5:    len_d = flange_length_reg;
            default: ;
        endcase
    end

    // multiplier operands: accumulated row entry times link entry
    always_comb begin
        ct_b  = BW'(ct_reg);
        st_b  = BW'(st_reg);
        one_b = BW'(mdhfk_pkg::ONE);
        a_b   = signed'(BW'(len_a));
        d_b   = signed'(BW'(len_d));
        a_op  = rot_reg[row_reg][k_reg];
        b_op  = '0;
        if (term_reg == 2'd3) begin
            case (k_reg)
                2'd0:    b_op = a_b;
                2'd1:    b_op = sa_pos ? -d_b : (sa_neg ? d_b : '0);
                2'd2:    b_op = ca_one ? d_b : '0;
                default: b_op = '0;
            endcase
        end else begin
            case ({k_reg, term_reg})
                4'b00_00: b_op = ct_b;
                4'b00_01: b_op = -st_b;
                4'b01_00: b_op = ca_one ? st_b : '0;
                4'b01_01: b_op = ca_one ? ct_b : '0;
                4'b01_10: b_op = sa_pos ? -one_b : (sa_neg ? one_b : '0);
                4'b10_00: b_op = sa_pos ? st_b : (sa_neg ? -st_b : '0);
                4'b10_01: b_op = sa_pos ? ct_b : (sa_neg ? -ct_b : '0);
                4'b10_10: b_op = ca_one ? one_b : '0;
                default:  b_op = '0;
            endcase
        end
    end

    // accumulate, round to nearest, saturate
    always_comb begin
        sum_n = sum_reg + SW'(prod_reg);
        rnd   = (sum_n + HALF) >>> mdhfk_pkg::FRAC_BITS;
        rot_c = (rnd > ONE_S) ? ONE_S : ((rnd < -ONE_S) ? -ONE_S : rnd);
        pos_s = rnd + SW'(pos_reg[row_reg]);
        pos_c = (pos_s > POS_MAX) ? POS_MAX : ((pos_s < POS_MIN) ? POS_MIN : pos_s);
    end

    // sequencer, frame state and output row register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            cordic_start_reg     <= 1'b0;
            base_height_reg      <= LW'(31326);
            shoulder_offset_reg  <= LW'(8126);
            upper_arm_length_reg <= LW'(27853);
            forearm_length_reg   <= LW'(27853);
            flange_length_reg    <= LW'(6554);
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    rot_reg[r][c] <= (r == c) ? mdhfk_pkg::ONE : '0;
                end
                pos_reg[r] <= '0;
            end
        end else begin
            cordic_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE_HEIGHT:      base_height_reg      <= cfg_data;
                    CFG_SHOULDER_OFFSET:  shoulder_offset_reg  <= cfg_data;
                    CFG_UPPER_ARM_LENGTH: upper_arm_length_reg <= cfg_data;
                    CFG_FOREARM_LENGTH:   forearm_length_reg   <= cfg_data;
                    CFG_FLANGE_LENGTH:    flange_length_reg    <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_joint <= 3'd5) begin
                        joint_reg        <= s_joint;
                        angle_reg        <= s_angle;
                        cordic_start_reg <= 1'b1;
                        state_reg        <= ST_SINCOS;
                        if (s_joint == 3'd0) begin
                            for (int r = 0; r < 3; r++) begin
                                for (int c = 0; c < 3; c++) begin
                                    rot_reg[r][c] <= (r == c) ? mdhfk_pkg::ONE : '0;
                                end
                                pos_reg[r] <= '0;
                            end
                        end
                    end
                end
                ST_SINCOS: begin
                    if (sc.done) begin
                        ct_reg    <= sc.cos_val;
                        st_reg    <= sc.sin_val;
                        row_reg   <= '0;
                        term_reg  <= '0;
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= a_op * b_op;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    state_reg <= ST_MUL;
                    if (k_reg == 2'd2) begin
                        k_reg   <= '0;
                        sum_reg <= '0;
                        if (term_reg == 2'd3) begin
                            // row finished: commit it and present it
                            for (int c = 0; c < 3; c++) begin
                                rot_reg[row_reg][c] <= nrot_reg[c];
                            end
                            pos_reg[row_reg] <= pos_c[PW-1:0];
                            term_reg  <= '0;
                            frame_reg <= joint_reg + 3'd1;
                            orow_reg  <= row_reg;
                            orx_reg   <= nrot_reg[0];
                            ory_reg   <= nrot_reg[1];
                            orz_reg   <= nrot_reg[2];
                            ooff_reg  <= pos_c[PW-1:0];
                            olast_reg <= (row_reg == 2'd2);
                            state_reg <= ST_OUT;
                        end else begin
                            nrot_reg[term_reg] <= rot_c[RW-1:0];
                            term_reg           <= term_reg + 2'd1;
                        end
                    end else begin
                        k_reg   <= k_reg + 2'd1;
                        sum_reg <= sum_n;
                    end
                end
                ST_OUT: begin
                    if (m_fire) begin
                        if (row_reg == 2'd2) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_frame   = frame_reg;
    assign m_row     = orow_reg;
    assign m_rot_x   = orx_reg;
    assign m_rot_y   = ory_reg;
    assign m_rot_z   = orz_reg;
    assign m_offset  = ooff_reg;
    assign m_last    = olast_reg;

    // one request in flight: no new request while a row is offered
    `MDHFK_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // last mark only on the z row
    `MDHFK_ASSERT_NOW(a_last_row, aclk, aresetn, m_valid && m_last, m_row == 2'd2)
    // a valid joint request starts work
    `MDHFK_ASSERT_NEXT(a_start, aclk, aresetn, s_valid && s_ready && s_joint <= 3'd5, !s_ready)
    // rotation x entry stays within +/-1.0
    `MDHFK_ASSERT_NOW(a_rot_sat, aclk, aresetn, m_valid,
        m_rot_x <= mdhfk_pkg::ONE && m_rot_x >= -mdhfk_pkg::ONE)

endmodule

>>> bench/mdh_forward_kinematics_chain_tb.sv
// Self-checking bench for the six-joint modified DH forward kinematics chain.
module mdh_forward_kinematics_chain_tb;

    localparam int  FLOW_LIMIT = 4000;   // cycles with no transfer on any channel
    localparam int  DRAIN_WAIT = 250;    // covers one dropped or in-flight joint
    localparam int  LONG_HOLD  = 450;
    localparam longint KINV    = 652032874;
    localparam longint ATAN_TAB [0:29] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

    // register indexes
    typedef enum logic [2:0] {
        REG_BASE_HEIGHT = 3'd0, REG_SHOULDER = 3'd1, REG_UPPER_ARM = 3'd2,
        REG_FOREARM = 3'd3, REG_FLANGE = 3'd4, REG_NONE_5 = 3'd5,
        REG_NONE_6 = 3'd6, REG_NONE_7 = 3'd7
    } reg_idx_t;

    typedef struct {
        logic [2:0]  joint;
        logic [15:0] angle;
    } joint_req_t;

    typedef struct {
        logic [2:0]                         frame;
        logic [1:0]                         row;
        logic signed [mdhfk_pkg::ROT_W-1:0] rx, ry, rz;
        logic signed [mdhfk_pkg::POS_W-1:0] off;
        logic                               last;
    } frame_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_joint = '0;
    logic [15:0] s_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_frame;
    logic [1:0] m_row;
    logic signed [mdhfk_pkg::ROT_W-1:0] m_rot_x, m_rot_y, m_rot_z;
    logic signed [mdhfk_pkg::POS_W-1:0] m_offset;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = REG_BASE_HEIGHT;
    logic [mdhfk_pkg::LEN_W-1:0] cfg_data = '0;

    joint_req_t joint_reqs[$];
    frame_row_t expected_rows[$];
    longint     chain_rot[9];
    longint     chain_pos[3];
    longint     link_len[5];
    int         fail_count = 0;
    int         hold_reqs = 0;
    int         stall_pct = 30;

    mdh_forward_kinematics_chain u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_joint(s_joint), .s_angle(s_angle),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame(m_frame), .m_row(m_row),
        .m_rot_x(m_rot_x), .m_rot_y(m_rot_y), .m_rot_z(m_rot_z),
        .m_offset(m_offset), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // CORDIC sine / cosine of a 16-bit binary angle, Q.16
    function automatic void joint_sincos(logic [15:0] ang, output longint c, output longint s);
        logic [31:0] z;
        logic        flip;
        longint      zz, x, y, dx, dy, one;
        z = {ang, 16'h0};
        one = longint'(1) <<< mdhfk_pkg::FRAC_BITS;
        flip = 1'b0;
        x = KINV;
        y = 0;
        if (((z + 32'h40000000) & 32'h80000000) != 0) begin
            z = z + 32'h80000000;
            flip = 1'b1;
        end
        zz = longint'(signed'(z));
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (zz >= 0) begin
                x -= dx; y += dy; zz -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; zz += ATAN_TAB[i];
            end
        end
        x = round_q(x, 30 - mdhfk_pkg::FRAC_BITS);
        y = round_q(y, 30 - mdhfk_pkg::FRAC_BITS);
        if (flip) begin
            x = -x; y = -y;
        end
        c = sat(x, -one, one);
        s = sat(y, -one, one);
    endfunction

    // advance the chain by one joint and queue its three rows; joints 6 and 7 are ignored
    function automatic void chain_advance(logic [2:0] j, logic [15:0] ang);
        longint ct, st, sa, ca, a, d, one, sum, acc;
        longint lnk[9], pl[3], nr[9], np[3];
        frame_row_t fr;
        one = longint'(1) <<< mdhfk_pkg::FRAC_BITS;
        if (j > 3'd5) return;
        joint_sincos(ang, ct, st);
        sa = (j == 1 || j == 3 || j == 5) ? 1 : (j == 4 ? -1 : 0);
        ca = (j == 0 || j == 2) ? 1 : 0;
        a = 0;
        d = 0;
        case (j)
            3'd0: d = link_len[REG_BASE_HEIGHT];
            3'd1: a = link_len[REG_SHOULDER];
            3'd2: a = link_len[REG_UPPER_ARM];
            3'd3: d = link_len[REG_FOREARM];
            3'd5: d = link_len[REG_FLANGE];
            default: ;
        endcase
        lnk = '{ct, -st, 0, st * ca, ct * ca, -sa * one, st * sa, ct * sa, ca * one};
        pl = '{a, -sa * d, ca * d};
        if (j == 3'd0) begin
            for (int k = 0; k < 9; k++) chain_rot[k] = (k % 4 == 0) ? one : 0;
            for (int k = 0; k < 3; k++) chain_pos[k] = 0;
        end
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                sum = 0;
                for (int k = 0; k < 3; k++) sum += chain_rot[r*3+k] * lnk[k*3+c];
                nr[r*3+c] = sat(round_q(sum, mdhfk_pkg::FRAC_BITS), -one, one);
            end
            for (int k = 0; k < 3; k++) acc += chain_rot[r*3+k] * pl[k];
            np[r] = sat(round_q(acc, mdhfk_pkg::FRAC_BITS) + chain_pos[r], -262144, 262143);
        end
        for (int k = 0; k < 9; k++) chain_rot[k] = nr[k];
        for (int r = 0; r < 3; r++) begin
            chain_pos[r] = np[r];
            fr.frame = j + 3'd1;
            fr.row = r[1:0];
            fr.rx = nr[r*3][mdhfk_pkg::ROT_W-1:0];
            fr.ry = nr[r*3+1][mdhfk_pkg::ROT_W-1:0];
            fr.rz = nr[r*3+2][mdhfk_pkg::ROT_W-1:0];
            fr.off = np[r][mdhfk_pkg::POS_W-1:0];
            fr.last = (r == 2);
            expected_rows.push_back(fr);
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // sender: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        logic take;
        joint_req_t jr;
        take = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) chain_advance(s_joint, s_angle);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (joint_reqs.size() > 0) begin
                    take = 1'b1;
                    jr = joint_reqs.pop_front();
                    s_joint <= jr.joint;
                    s_angle <= jr.angle;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                s_valid <= take;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        frame_row_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("unexpected result frame", m_frame, 0);
            end else begin
                want = expected_rows.pop_front();
                if (m_frame !== want.frame) report_mismatch("frame", m_frame, want.frame);
                if (m_row !== want.row) report_mismatch("row", m_row, want.row);
                if (m_rot_x !== want.rx) report_mismatch("rot_x", m_rot_x, want.rx);
                if (m_rot_y !== want.ry) report_mismatch("rot_y", m_rot_y, want.ry);
                if (m_rot_z !== want.rz) report_mismatch("rot_z", m_rot_z, want.rz);
                if (m_offset !== want.off) report_mismatch("offset", m_offset, want.off);
                if (m_last !== want.last) report_mismatch("last", m_last, want.last);
            end
        end
    end

    // watchdog on stalled traffic
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= FLOW_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_rows.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_req(logic [2:0] j, logic [15:0] ang);
        joint_req_t jr;
        jr.joint = j;
        jr.angle = ang;
        joint_reqs.push_back(jr);
    endtask

    task automatic wait_idle();
        wait (joint_reqs.size() == 0 && !s_valid && expected_rows.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // writes the five lengths, then the unused indexes; block must be idle
    task automatic write_lengths(logic [mdhfk_pkg::LEN_W-1:0] v0, v1, v2, v3, v4);
        logic [mdhfk_pkg::LEN_W-1:0] vals[8];
        vals = '{v0, v1, v2, v3, v4, mdhfk_pkg::LEN_W'($urandom),
                 mdhfk_pkg::LEN_W'($urandom), mdhfk_pkg::LEN_W'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            if (i <= REG_FLANGE) link_len[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_chains(int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 8) begin
                for (int j = 0; j < 6; j++) add_req(j[2:0], 16'($urandom));
                n += 6;
            end else begin
                add_req(3'($urandom), 16'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        link_len = '{31326, 8126, 27853, 27853, 6554};
        for (int k = 0; k < 9; k++) chain_rot[k] = (k % 4 == 0) ? 65536 : 0;
        chain_pos = '{0, 0, 0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: boundary angles, every joint, dropped joints, out of order
        add_req(3'd3, 16'h2000);
        add_req(3'd0, 16'h0000);
        add_req(3'd1, 16'h4000);
        add_req(3'd2, 16'h8000);
        add_req(3'd3, 16'hC000);
        add_req(3'd4, 16'hFFFF);
        add_req(3'd5, 16'h0001);
        add_req(3'd6, 16'h1234);
        add_req(3'd7, 16'hFFFF);
        add_req(3'd0, 16'h3FFF);
        add_req(3'd1, 16'hBFFF);
        add_req(3'd2, 16'h4001);
        add_req(3'd5, 16'h7FFF);
        add_req(3'd4, 16'h8001);
        add_req(3'd4, 16'h5555);
        add_req(3'd3, 16'hAAAA);
        wait_idle();

        // longest links: drives the offsets into saturation
        write_lengths('1, '1, '1, '1, '1);
        for (int r = 0; r < 3; r++)
            for (int j = 0; j < 6; j++) add_req(j[2:0], 16'h0000);
        add_req(3'd0, 16'h8000);
        add_req(3'd1, 16'hC000);
        add_req(3'd3, 16'h0000);
        wait_idle();

        // zero links; receiver holds off while the sender keeps going
        write_lengths('0, '0, '0, '0, '0);
        stall_pct = 10;
        hold_reqs = hold_reqs + 1;
        random_chains(60);
        wait_idle();

        write_lengths(mdhfk_pkg::LEN_W'($urandom), mdhfk_pkg::LEN_W'($urandom),
                      mdhfk_pkg::LEN_W'($urandom), mdhfk_pkg::LEN_W'($urandom),
                      mdhfk_pkg::LEN_W'($urandom));
        stall_pct = 50;
        random_chains(140);
        wait_idle();

        write_lengths(mdhfk_pkg::LEN_W'(31326), mdhfk_pkg::LEN_W'(8126),
                      mdhfk_pkg::LEN_W'(27853), mdhfk_pkg::LEN_W'(27853),
                      mdhfk_pkg::LEN_W'(6554));
        stall_pct = 0;
        random_chains(70);
        wait_idle();
        stall_pct = 30;
        random_chains(70);
        wait_idle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mdhfk_pkg.sv
hdl/mdhfk_cordic.sv
hdl/mdh_forward_kinematics_chain.sv
bench/mdh_forward_kinematics_chain_tb.sv
